>>> src/b64d_pkg.sv
`timescale 1ns / 1ps

package b64d_pkg;

   localparam int SEXTET_W = 6;
   localparam int BYTE_W   = 8;
   localparam int GROUP_N  = 4;
   localparam int HELD_N   = GROUP_N - 1;

   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_UNDER   = 8'h5F;

   localparam logic [7:0] UPPER_OFS  = 8'd65;
   localparam logic [7:0] LOWER_OFS  = 8'd71;
   localparam logic [7:0] DIGIT_OFS  = 8'd4;
   localparam logic [SEXTET_W-1:0] SX_62 = 6'd62;
   localparam logic [SEXTET_W-1:0] SX_63 = 6'd63;

   typedef logic [SEXTET_W-1:0] sextet_type;
   typedef logic [BYTE_W-1:0]   byte_type;

   typedef struct packed {
      logic       ok;
      sextet_type sx;
   } map_type;

   // Closed group handed from the group stage to the output buffer.
   typedef struct packed {
      logic                 fire;
      logic [1:0]           nbytes;
      logic [2:0][BYTE_W-1:0] bytes;
   } load_type;

   function automatic map_type map_char(input logic [7:0] c);
      map_type    m;
      logic [7:0] v;
      v    = 8'd0;
      m.ok = 1'b1;
      priority if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         v = c - UPPER_OFS;
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         v = c - LOWER_OFS;
      end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
         v = c + DIGIT_OFS;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
         v = {2'b00, SX_62};
      end else if (c == CH_SLASH || c == CH_UNDER) begin
         v = {2'b00, SX_63};
      end else begin
         v    = 8'd0;
         m.ok = 1'b0;
      end
      m.sx = v[SEXTET_W-1:0];
      return m;
   endfunction

endpackage

>>> src/b64d_ifs.sv
`timescale 1ns / 1ps

interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       end_of_stream;

   modport source (output valid, output char_in, output end_of_stream, input ready);
   modport sink   (input valid, input char_in, input end_of_stream, output ready);
endinterface

interface b64d_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       run_last;

   modport source (output valid, output data_byte, output run_last, input ready);
   modport sink   (input valid, input data_byte, input run_last, output ready);
endinterface

>>> src/b64d_group.sv
`timescale 1ns / 1ps

module b64d_group (
   input  logic                clock,
   input  logic                reset,
   b64d_req_if.sink            req_bus,
   input  logic                buf_free,
   output b64d_pkg::load_type  load
);

   b64d_pkg::map_type req_map;

   logic                 s1_valid_ff, s1_valid_in;
   b64d_pkg::sextet_type s1_sx_ff, s1_sx_in;
   logic                 s1_ok_ff, s1_ok_in;
   logic                 s1_eos_ff, s1_eos_in;

   logic [1:0]                                    pos_ff, pos_in;
   logic [1:0]                                    inv_ff, inv_in;
   logic [b64d_pkg::HELD_N-1:0][b64d_pkg::SEXTET_W-1:0] held_ff, held_in;

   logic [b64d_pkg::GROUP_N-1:0][b64d_pkg::SEXTET_W-1:0] s;
   logic [2:0] count;
   logic [2:0] invalid;
   logic [2:0] eff;
   logic [2:0] eff_m1;
   logic       closes;
   logic       s1_adv;
   logic       req_fire;

   assign req_map  = b64d_pkg::map_char(req_bus.char_in);
   assign req_fire = req_bus.valid && req_bus.ready;

   always_comb begin
      s          = {{b64d_pkg::SEXTET_W{1'b0}}, held_ff[2], held_ff[1], held_ff[0]};
      s[pos_ff]  = s1_sx_ff;
      count      = {1'b0, pos_ff} + 3'd1;
      invalid    = {1'b0, inv_ff} + {2'b00, ~s1_ok_ff};
      closes     = (count == 3'd4) || s1_eos_ff;
      eff        = (count > invalid) ? (count - invalid) : 3'd0;
      eff_m1     = eff - 3'd1;
   end

   assign s1_adv        = s1_valid_ff && (!closes || buf_free);
   assign req_bus.ready = !s1_valid_ff || s1_adv;

   always_comb begin
      load.fire     = s1_adv && closes;
      load.nbytes   = (eff > 3'd1) ? eff_m1[1:0] : 2'd0;
      load.bytes[0] = {s[0], s[1][5:4]};
      load.bytes[1] = {s[1][3:0], s[2][5:2]};
      load.bytes[2] = {s[2][1:0], s[3]};
   end

   // input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_sx_in    = s1_sx_ff;
      s1_ok_in    = s1_ok_ff;
      s1_eos_in   = s1_eos_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_sx_in    = req_map.sx;
         s1_ok_in    = req_map.ok;
         s1_eos_in   = req_bus.end_of_stream;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // group state
   always_comb begin
      pos_in  = pos_ff;
      inv_in  = inv_ff;
      held_in = held_ff;
      if (s1_adv) begin
         if (closes) begin
            pos_in  = 2'd0;
            inv_in  = 2'd0;
            held_in = '0;
         end else begin
            held_in[pos_ff] = s1_sx_ff;
            pos_in          = count[1:0];
            inv_in          = invalid[1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pos_ff      <= 2'd0;
         inv_ff      <= 2'd0;
         held_ff     <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         pos_ff      <= pos_in;
         inv_ff      <= inv_in;
         held_ff     <= held_in;
      end
      s1_sx_ff  <= s1_sx_in;
      s1_ok_ff  <= s1_ok_in;
      s1_eos_ff <= s1_eos_in;
   end

endmodule

>>> src/b64d_obuf.sv
`timescale 1ns / 1ps

module b64d_obuf (
   input  logic               clock,
   input  logic               reset,
   input  b64d_pkg::load_type load,
   output logic               buf_free,
   b64d_rsp_if.source         rsp_bus
);

   logic [1:0]                            cnt_ff, cnt_in;
   logic [2:0][b64d_pkg::BYTE_W-1:0]      bytes_ff, bytes_in;
   logic                                  pop;

   assign pop      = (cnt_ff != 2'd0) && rsp_bus.ready;
   assign buf_free = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_bus.ready);

   assign rsp_bus.valid     = (cnt_ff != 2'd0);
   assign rsp_bus.data_byte = bytes_ff[0];
   assign rsp_bus.run_last  = (cnt_ff == 2'd1);

   always_comb begin
      cnt_in   = cnt_ff;
      bytes_in = bytes_ff;
      if (load.fire) begin
         cnt_in   = load.nbytes;
         bytes_in = load.bytes;
      end else if (pop) begin
         cnt_in   = cnt_ff - 2'd1;
         bytes_in = {{b64d_pkg::BYTE_W{1'b0}}, bytes_ff[2], bytes_ff[1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      bytes_ff <= bytes_in;
   end

endmodule

>>> src/base64_stream_decoder.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                         Beat
// req_bus   in   char_in[7:0], end_of_stream     one text character
// rsp_bus   out  data_byte[7:0], run_last        one decoded byte
//
// Takes one character beat per cycle unless stalled. A character is mapped to
// its sextet on the way into the input register and joins the open group from there.
// A group that closes puts 0..3 bytes into the output buffer; they leave one
// beat per cycle while rsp_bus.ready is high, straight from the buffer register.
// Reset (synchronous) empties the input register, the group and the buffer.
// The input stalls only when a closing group finds the buffer not yet free:
// holding more than its final beat, or its final beat while rsp_bus.ready is low.

module base64_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   b64d_req_if.sink    req_bus,
   b64d_rsp_if.source  rsp_bus
);

   b64d_pkg::load_type load;
   logic               buf_free;

   // character decode and group assembly
   b64d_group u_group (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .buf_free (buf_free),
      .load     (load)
   );

   // byte queue, drained one beat per cycle while rsp_bus.ready is high
   b64d_obuf u_obuf (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .buf_free (buf_free),
      .rsp_bus  (rsp_bus)
   );

`ifndef NO_ASSERTIONS
   // a closed group never overwrites bytes still waiting to go out
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load.fire |-> buf_free)
      else $error("group closed into a busy output buffer");

   // a group with bytes shows its first beat next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      (load.fire && load.nbytes != 2'd0) |=> rsp_bus.valid)
      else $error("loaded bytes not presented");

   // a beat that is not the last of its run is followed by another
   a_run_cont: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && !rsp_bus.run_last) |=> rsp_bus.valid)
      else $error("byte run cut short");
`endif

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

// Bench for base64_stream_decoder.
//
// Characters go in on req_bus one beat at a time, and every accepted beat is
// run through a local model of the group logic: sextet mapping, the invalid
// count, and closing on the fourth character or on end_of_stream. Each byte
// that a closing group yields goes onto a queue of expected bytes. The
// response monitor pops one entry per rsp_bus beat and compares data_byte and
// run_last.
//
// The tests run in order: directed alphabet edges, padding and junk inside a
// group, short groups closed by end_of_stream, a long response hold-off while
// the sender keeps streaming, and a random stream that is mostly well formed
// groups mixed with raw noise.

module tb_top;

   localparam b64d_pkg::byte_type CH_PAD = 8'h3D;   // '='

   typedef struct packed {
      b64d_pkg::byte_type data;
      logic               last;
   } dec_byte_type;

   logic clock;
   logic reset;

   b64d_req_if req_bus ();
   b64d_rsp_if rsp_bus ();

   base64_stream_decoder uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Bytes still owed by the decoder, oldest first.
   dec_byte_type pending_bytes [$];
   int           error_count = 0;

   // Open group as the decoder should hold it.
   logic [1:0]           grp_pos;
   b64d_pkg::sextet_type grp_sx [3];
   logic [1:0]           grp_bad;

   // Sender burst state. Only the stimulus process writes these.
   int         burst_left   = 0;
   bit         gaps_enabled = 1'b1;

   // Hold-off request to the response side. The stimulus bumps hold_seq, and
   // the receiver picks up hold_len when it sees the change.
   int         hold_len  = 0;
   int         hold_seq  = 0;
   int         hold_seen = 0;
   int         hold_left = 0;
   int         rx_cycle  = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // Group model
   // ------------------------------------------------------------------

   // Returns 1 when the character belongs to either alphabet.
   function automatic logic char_sextet(input b64d_pkg::byte_type c,
                                        output b64d_pkg::sextet_type sx);
      b64d_pkg::byte_type t;
      t = 8'd0;
      char_sextet = 1'b1;
      if (c >= b64d_pkg::CH_UPPER_A && c <= b64d_pkg::CH_UPPER_Z)
         t = c - b64d_pkg::CH_UPPER_A;
      else if (c >= b64d_pkg::CH_LOWER_A && c <= b64d_pkg::CH_LOWER_Z)
         t = c - b64d_pkg::CH_LOWER_A + 8'd26;
      else if (c >= b64d_pkg::CH_DIGIT_0 && c <= b64d_pkg::CH_DIGIT_9)
         t = c - b64d_pkg::CH_DIGIT_0 + 8'd52;
      else if (c == b64d_pkg::CH_PLUS || c == b64d_pkg::CH_MINUS)
         t = 8'd62;
      else if (c == b64d_pkg::CH_SLASH || c == b64d_pkg::CH_UNDER)
         t = 8'd63;
      else
         char_sextet = 1'b0;   // junk or padding: zero sextet, counts as invalid
      sx = t[5:0];
   endfunction

   function automatic void clear_group();
      grp_pos = '0;
      grp_bad = '0;
      foreach (grp_sx[i]) grp_sx[i] = '0;
   endfunction

   // Folds one accepted character into the group; queues the bytes of a
   // group that closes on it.
   function automatic void predict_char(input b64d_pkg::byte_type c, input logic eos);
      b64d_pkg::sextet_type sx;
      b64d_pkg::sextet_type s [4];
      b64d_pkg::byte_type   b [3];
      logic                 ok;
      int                   n, bad, good, nb;
      dec_byte_type         d;

      ok   = char_sextet(c, sx);
      s[0] = grp_sx[0];
      s[1] = grp_sx[1];
      s[2] = grp_sx[2];
      s[3] = '0;
      n    = grp_pos;
      s[n] = sx;
      n    = n + 1;
      bad  = grp_bad + (ok ? 0 : 1);

      if (n < 4 && !eos) begin
         grp_sx[n-1] = sx;
         grp_pos     = n[1:0];
         grp_bad     = bad[1:0];
         return;
      end

      // Closing: bytes are packed by position, junk keeps its zero slot.
      good = (n > bad) ? n - bad : 0;
      nb   = (good > 1) ? good - 1 : 0;
      b[0] = {s[0], s[1][5:4]};
      b[1] = {s[1][3:0], s[2][5:2]};
      b[2] = {s[2][1:0], s[3]};
      for (int k = 0; k < nb; k++) begin
         d.data = b[k];
         d.last = (k == nb - 1);
         pending_bytes = {pending_bytes, d};
      end
      clear_group();
   endfunction

   // ------------------------------------------------------------------
   // Response side: checks every beat, stalls on its own pattern
   // ------------------------------------------------------------------
   initial begin
      dec_byte_type want;
      rsp_bus.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_bytes.size() == 0) begin
               $error("unexpected byte beat: data_byte %02h run_last %0b",
                      rsp_bus.data_byte, rsp_bus.run_last);
               error_count++;
            end else begin
               want = pending_bytes.pop_front();
               if (rsp_bus.data_byte !== want.data) begin
                  $error("data_byte mismatch: expected %02h actual %02h",
                         want.data, rsp_bus.data_byte);
                  error_count++;
               end
               if (rsp_bus.run_last !== want.last) begin
                  $error("run_last mismatch: expected %0b actual %0b",
                         want.last, rsp_bus.run_last);
                  error_count++;
               end
            end
         end

         rx_cycle <= rx_cycle + 1;
         if (hold_seq != hold_seen) begin
            // long hold-off, counted down here
            hold_seen     <= hold_seq;
            hold_left     <= hold_len;
            rsp_bus.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            rsp_bus.ready <= (hold_left == 1);
         end else begin
            // stall pattern chosen by rx_cycle[8:7]
            case (rx_cycle[8:7])
               2'd0: rsp_bus.ready <= 1'b1;
               2'd1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2'd2: rsp_bus.ready <= (rx_cycle[1:0] == 2'd0);
               default: rsp_bus.ready <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Offers one character; returns at the edge that accepts it, valid still high.
   task automatic send_char(input b64d_pkg::byte_type c, input logic eos);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = (!gaps_enabled || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid         <= 1'b1;
      req_bus.char_in       <= c;
      req_bus.end_of_stream <= eos;
      do @(posedge clock); while (!req_bus.ready);
      predict_char(c, eos);
   endtask

   task automatic send_text(input string s, input logic eos_on_last);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], eos_on_last && (i == s.len() - 1));
   endtask

   // Drops valid and waits for every owed byte; at least one edge passes.
   task automatic pause_until_drained();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_bytes.size() != 0);
   endtask

   function automatic b64d_pkg::byte_type b64_char(input int v, input logic url);
      if (v < 26) return 8'(b64d_pkg::CH_UPPER_A + v);
      if (v < 52) return 8'(b64d_pkg::CH_LOWER_A + (v - 26));
      if (v < 62) return 8'(b64d_pkg::CH_DIGIT_0 + (v - 52));
      if (v == 62) return url ? b64d_pkg::CH_MINUS : b64d_pkg::CH_PLUS;
      return url ? b64d_pkg::CH_UNDER : b64d_pkg::CH_SLASH;
   endfunction

   function automatic b64d_pkg::byte_type rand_b64_char();
      return b64_char($urandom_range(0, 63), 1'($urandom_range(0, 1)));
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Range ends of the letter and digit classes, and both spellings of 62.
   task automatic test_alphabet_extremes();
      send_text("AZaz", 1'b0);
      send_text("09+-", 1'b0);
      pause_until_drained();
   endtask

   // Padding, junk between good characters, and raw 00/FF bytes.
   task automatic test_padding_and_junk();
      send_text("/_Q=", 1'b0);     // trailing pad: two bytes
      send_text("Q=QQ", 1'b0);     // junk mid-group keeps its zero slot
      send_char(8'hFF, 1'b0);
      send_char(8'h00, 1'b0);
      send_text("AB", 1'b0);       // two junk: one byte
      pause_until_drained();
   endtask

   // end_of_stream closing short groups, including one with no bytes.
   task automatic test_end_of_stream();
      send_text("QU", 1'b1);       // one byte
      send_char(CH_PAD, 1'b1);     // nothing good: no bytes
      send_text("Tm9", 1'b1);      // two bytes
      send_text("==", 1'b1);       // all pad, closed early
      pause_until_drained();
   endtask

   // Receiver holds off long while full groups keep coming back to back.
   task automatic test_rsp_holdoff();
      gaps_enabled = 1'b0;
      hold_len <= 120;
      hold_seq <= hold_seq + 1;
      for (int i = 0; i < 48; i++)
         send_char(rand_b64_char(), 1'b0);
      gaps_enabled = 1'b1;
      pause_until_drained();
   endtask

   // Mostly well formed groups with random content; the rest is short
   // groups closed by end_of_stream and raw noise.
   task automatic test_random_stream(input int n_items);
      int                 sent, kind, pad, len;
      logic               eos_end;
      b64d_pkg::byte_type c;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 9) == 0)
            gaps_enabled = 1'($urandom_range(0, 1));
         kind = $urandom_range(0, 99);
         if (kind < 65) begin
            pad     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
            eos_end = ($urandom_range(0, 7) == 0);
            for (int k = 0; k < 4; k++) begin
               c = (k >= 4 - pad) ? CH_PAD : rand_b64_char();
               send_char(c, eos_end && k == 3);
            end
            sent += 4;
         end else if (kind < 85) begin
            len = $urandom_range(1, 3);
            for (int k = 0; k < len; k++)
               send_char(rand_b64_char(), k == len - 1);
            sent += len;
         end else begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
               c = 8'($urandom_range(0, 255));
               send_char(c, $urandom_range(0, 9) == 0);
            end
            sent += len;
         end
      end
      gaps_enabled = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      clear_group();
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.char_in       <= '0;
      req_bus.end_of_stream <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_alphabet_extremes();
      test_padding_and_junk();
      test_end_of_stream();
      test_rsp_holdoff();
      test_random_stream(120);

      // all sent: wait out the owed bytes, then a tail for strays
      pause_until_drained();
      repeat (20) @(posedge clock);

      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
